// File: hw/rtl/svn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svn_pkg
// Shared constants, types and the blend weight table for the smoothed value
// noise core.
// ----------------------------------------------------------------------------
package svn_pkg;

    localparam int FRAC_BITS = 8;
    localparam int INT_BITS  = 16;
    localparam int CW        = INT_BITS + FRAC_BITS;
    localparam int COORD_W   = 24;
    localparam int NOISE_W   = 18;
    localparam int WGT_W     = 17;
    localparam int WT_DEPTH  = 1 << FRAC_BITS;

    // Pipeline stage numbers.
    localparam int ST_SPLIT = 0;
    localparam int ST_SEED  = 1;
    localparam int ST_SQR   = 2;
    localparam int ST_POLY  = 3;
    localparam int ST_LAT   = 4;
    localparam int ST_SMTH  = 5;
    localparam int ST_PRDX  = 6;
    localparam int ST_MIXX  = 7;
    localparam int ST_PRDY  = 8;
    localparam int ST_OUT   = 9;
    localparam int NSTG     = 10;

    localparam int VW = 38;
    localparam int DW = VW + 1;
    localparam int PW = DW + WGT_W;

    localparam logic [31:0] HASH_YMUL = 32'd2999;
    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD1 = 32'd792222;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
    localparam logic [31:0] LAT_ONE   = 32'h4000_0000;

    localparam logic [63:0] COEF_C1 = 64'd2649351758;
    localparam logic [63:0] COEF_C2 = 64'd2179004481;
    localparam logic [63:0] COEF_C3 = 64'd716863740;
    localparam logic [63:0] COEF_C4 = 64'd126342165;
    localparam logic [63:0] COEF_C5 = 64'd13854969;

    typedef logic [WGT_W-1:0] wgt_t;
    typedef logic [15:0][31:0] grid_t;
    typedef wgt_t wtab_t [WT_DEPTH];

    typedef struct packed {
        logic [NSTG-1:0] en;
    } pipe_ctl_t;

    function automatic logic [63:0] half_weight(input logic [63:0] u);
        logic [63:0] s;
        logic [63:0] acc;
        s   = (u * u) >> 2;
        acc = COEF_C5;
        acc = COEF_C4 - ((s * acc) >> 30);
        acc = COEF_C3 - ((s * acc) >> 30);
        acc = COEF_C2 - ((s * acc) >> 30);
        acc = COEF_C1 - ((s * acc) >> 30);
        acc = (s * acc) >> 30;
        return (acc + 64'd8192) >> 14;
    endfunction

    function automatic wtab_t build_wtab();
        wtab_t       tab;
        logic [63:0] t;
        logic [63:0] h;
        logic [63:0] w;
        for (int i = 0; i < WT_DEPTH; i++) begin
            t = (64'(i) << (16 - FRAC_BITS)) & 64'hFFFF;
            if (t <= 64'd32768) begin
                w = half_weight(t);
            end else begin
                h = half_weight(64'd65536 - t);
                w = (h > 64'd65536) ? 64'd0 : 64'd65536 - h;
            end
            if (w > 64'd65536) begin
                w = 64'd65536;
            end
            tab[i] = WGT_W'(w);
        end
        return tab;
    endfunction

    localparam wtab_t W_TABLE = build_wtab();

endpackage
`default_nettype wire

// File: hw/rtl/svn_coord_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svn_coord_if
// Coordinate channel: valid/ready with one x/y word.
// ----------------------------------------------------------------------------
interface svn_coord_if;
    import svn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/svn_noise_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svn_noise_if
// Noise channel: valid/ready with one noise word.
// ----------------------------------------------------------------------------
interface svn_noise_if;
    import svn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/svn_lattice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svn_lattice
// Hashes the 4x4 lattice neighborhood of one coordinate over four stages and
// looks up both blend weights.
// ----------------------------------------------------------------------------
module svn_lattice
    import svn_pkg::*;
(
    input  wire logic                 clk,
    input  wire pipe_ctl_t            ctl,
    input  wire logic [31:0]          ix,
    input  wire logic [31:0]          iy,
    input  wire logic [FRAC_BITS-1:0] fx,
    input  wire logic [FRAC_BITS-1:0] fy,
    output grid_t                     lat,
    output wgt_t                      wx,
    output wgt_t                      wy
);

    grid_t n1_next;
    grid_t n1_reg, n2_reg, nn2_reg, n3_reg, m3_reg, lat_reg;
    wgt_t  wx1_reg, wy1_reg, wx2_reg, wy2_reg, wx3_reg, wy3_reg, wx4_reg, wy4_reg;
    logic [3:0][31:0] ym;

    // Grid entry j*4+k is lattice point (ix+k-1, iy+j-1).
    always_comb
    begin
        logic [31:0] xv;
        logic [31:0] nv;
        for (int j = 0; j < 4; j++) begin
            ym[j] = (iy + 32'(j) - 32'd1) * HASH_YMUL;
        end
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
                xv = ix + 32'(k) - 32'd1;
                nv = xv + ym[j];
                n1_next[j*4+k] = (nv << 13) ^ nv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SEED]) begin
            n1_reg  <= n1_next;
            wx1_reg <= W_TABLE[fx];
            wy1_reg <= W_TABLE[fy];
        end
        if (ctl.en[ST_SQR]) begin
            n2_reg  <= n1_reg;
            wx2_reg <= wx1_reg;
            wy2_reg <= wy1_reg;
            for (int i = 0; i < 16; i++) begin
                nn2_reg[i] <= n1_reg[i] * n1_reg[i];
            end
        end
        if (ctl.en[ST_POLY]) begin
            n3_reg  <= n2_reg;
            wx3_reg <= wx2_reg;
            wy3_reg <= wy2_reg;
            for (int i = 0; i < 16; i++) begin
                m3_reg[i] <= nn2_reg[i] * HASH_MUL + HASH_ADD1;
            end
        end
        if (ctl.en[ST_LAT]) begin
            wx4_reg <= wx3_reg;
            wy4_reg <= wy3_reg;
            for (int i = 0; i < 16; i++) begin
                lat_reg[i] <= LAT_ONE
                            - {1'b0, 31'(n3_reg[i] * m3_reg[i] + HASH_ADD2)};
            end
        end
    end

    assign lat = lat_reg;
    assign wx  = wx4_reg;
    assign wy  = wy4_reg;

endmodule
`default_nettype wire

// File: hw/rtl/svn_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svn_interp
// Smooths the four corner values, blends them in x then y and rounds the
// result to Q2.16 with saturation.
// ----------------------------------------------------------------------------
module svn_interp
    import svn_pkg::*;
(
    input  wire logic                      clk,
    input  wire pipe_ctl_t                 ctl,
    input  wire grid_t                     lat,
    input  wire wgt_t                      wx,
    input  wire wgt_t                      wy,
    output logic signed [NOISE_W-1:0]      noise_value
);

    logic signed [VW-1:0] v_next [4];
    logic signed [VW-1:0] v_reg [4];
    wgt_t                 wx5_reg, wy5_reg, wy6_reg, wy7_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [VW-1:0] v1_6_reg, v3_6_reg, i1_reg, i2_reg, i1_8_reg;
    logic signed [NOISE_W-1:0] out_reg;

    logic signed [PW-1:0] p1_next, p2_next, p3_next;
    logic signed [VW-1:0] i1_next, i2_next, r_next;
    logic signed [VW:0]   r_round;
    logic signed [VW-18:0] q;
    logic signed [NOISE_W-1:0] out_next;

    function automatic logic signed [VW-1:0] gval(input grid_t g, input int r, input int c);
        return VW'($signed(g[r*4+c]));
    endfunction

    // Corner d (bit 0: x offset, bit 1: y offset) is centered on grid (dy+1, dx+1).
    always_comb
    begin
        int r;
        int c;
        logic signed [VW-1:0] corners;
        logic signed [VW-1:0] sides;
        for (int d = 0; d < 4; d++) begin
            r = (d >> 1) + 1;
            c = (d & 1) + 1;
            corners = gval(lat, r-1, c-1) + gval(lat, r-1, c+1)
                    + gval(lat, r+1, c-1) + gval(lat, r+1, c+1);
            sides   = gval(lat, r, c-1) + gval(lat, r, c+1)
                    + gval(lat, r-1, c) + gval(lat, r+1, c);
            v_next[d] = corners + (sides <<< 1) + (gval(lat, r, c) <<< 2);
        end
    end

    always_comb
    begin
        logic signed [PW-1:0] sh1;
        logic signed [PW-1:0] sh2;
        logic signed [PW-1:0] sh3;
        p1_next = (PW'(v_reg[1]) - PW'(v_reg[0])) * $signed({1'b0, wx5_reg});
        p2_next = (PW'(v_reg[3]) - PW'(v_reg[2])) * $signed({1'b0, wx5_reg});
        sh1     = p1_reg >>> 16;
        sh2     = p2_reg >>> 16;
        i1_next = v1_6_reg + VW'(sh1);
        i2_next = v3_6_reg + VW'(sh2);
        p3_next = (PW'(i2_reg) - PW'(i1_reg)) * $signed({1'b0, wy7_reg});
        sh3     = p3_reg >>> 16;
        r_next  = i1_8_reg + VW'(sh3);
        r_round = (VW+1)'(r_next) + (VW+1)'(32'sd131072);
        q       = (VW-17)'(r_round >>> 18);
        if (q > (VW-17)'(65536)) begin
            out_next = NOISE_W'(65536);
        end else if (q < -(VW-17)'(65536)) begin
            out_next = -NOISE_W'(65536);
        end else begin
            out_next = NOISE_W'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SMTH]) begin
            v_reg   <= v_next;
            wx5_reg <= wx;
            wy5_reg <= wy;
        end
        if (ctl.en[ST_PRDX]) begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            v1_6_reg <= v_reg[0];
            v3_6_reg <= v_reg[2];
            wy6_reg  <= wy5_reg;
        end
        if (ctl.en[ST_MIXX]) begin
            i1_reg  <= i1_next;
            i2_reg  <= i2_next;
            wy7_reg <= wy6_reg;
        end
        if (ctl.en[ST_PRDY]) begin
            p3_reg   <= p3_next;
            i1_8_reg <= i1_reg;
        end
        if (ctl.en[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;

endmodule
`default_nettype wire

// File: hw/rtl/smoothed_value_noise_2d_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_value_noise_2d_core
// Smoothed, cosine interpolated 2D value noise from fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   The coord channel takes one word with coord_x and coord_y (signed, with
//   FRAC_BITS fraction bits). The noise channel returns one Q2.16 noise word
//   for each coordinate word, in order.
//   The core is a ten-stage pipeline: split, hash seed, square, polynomial,
//   lattice value, smoothing, x product, x blend, y product, output rounding.
//   Throughput is one word per cycle while noise.ready is high.
//   Every stage holds a valid bit.
//   When the receiver stalls, a full stage holds its word and stages with a
//   bubble keep filling, so coord.ready drops only once all ten stages are
//   full. Nothing is lost or repeated.
//   Reset clears all valid bits; no state survives between words.
// ----------------------------------------------------------------------------
module smoothed_value_noise_2d_core
    import svn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    svn_coord_if.sink  coord,
    svn_noise_if.source noise
);

    logic [NSTG-1:0]      vld_reg;
    pipe_ctl_t            ctl;
    logic [31:0]          ix_reg, iy_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [31:0]          ix_next, iy_next;
    logic [FRAC_BITS-1:0] fx_next, fy_next;
    grid_t                lat;
    wgt_t                 wx, wy;

    always_comb
    begin
        ctl.en[NSTG-1] = !vld_reg[NSTG-1] || noise.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ctl.en[k] = !vld_reg[k] || ctl.en[k+1];
        end
    end

    // Integer part truncates toward zero; the fraction is taken as a magnitude.
    always_comb
    begin
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-1:0]        mx;
        logic [CW-1:0]        my;
        logic [31:0]          px;
        logic [31:0]          py;
        cx = CW'(coord.coord_x);
        cy = CW'(coord.coord_y);
        mx = cx[CW-1] ? CW'(-cx) : CW'(cx);
        my = cy[CW-1] ? CW'(-cy) : CW'(cy);
        px = 32'(mx >> FRAC_BITS);
        py = 32'(my >> FRAC_BITS);
        ix_next = cx[CW-1] ? 32'd0 - px : px;
        iy_next = cy[CW-1] ? 32'd0 - py : py;
        fx_next = mx[FRAC_BITS-1:0];
        fy_next = my[FRAC_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (ctl.en[ST_SPLIT]) begin
                vld_reg[ST_SPLIT] <= coord.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ctl.en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SPLIT]) begin
            ix_reg <= ix_next;
            iy_reg <= iy_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
    end

    svn_lattice u_lattice (
        .clk (clk),
        .ctl (ctl),
        .ix  (ix_reg),
        .iy  (iy_reg),
        .fx  (fx_reg),
        .fy  (fy_reg),
        .lat (lat),
        .wx  (wx),
        .wy  (wy)
    );

    svn_interp u_interp (
        .clk         (clk),
        .ctl         (ctl),
        .lat         (lat),
        .wx          (wx),
        .wy          (wy),
        .noise_value (noise.noise_value)
    );

    assign coord.ready = ctl.en[ST_SPLIT];
    assign noise.valid = vld_reg[NSTG-1];

endmodule
`default_nettype wire
